// ----- rtl/cbcc_pkg.sv -----
// ============================================================================
// cbcc_pkg: shared types, constants and a function
// Field widths, operation and class codes, the queue entry format and the
// hit-count bucketing function of the coverage bitmap classifier.
// ============================================================================
package cbcc_pkg;

    localparam int IDX_W        = 16;
    localparam int VAL_W        = 8;
    localparam int CNT_W        = 17;
    localparam int FUNC_W       = 2;
    localparam int CLS_W        = 2;
    localparam int MAP_SIZE_DEF = 65536;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Operation codes carried on tuser of the input side
    localparam logic [FUNC_W-1:0] FN_CMP_BKT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CMP_RAW = 2'd1;
    localparam logic [FUNC_W-1:0] FN_MERGE   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_BUCKET  = 2'd3;

    // Entry classes carried on tuser of the output side
    localparam logic [CLS_W-1:0] CLS_NONE       = 2'd0;
    localparam logic [CLS_W-1:0] CLS_NEW_BUCKET = 2'd1;
    localparam logic [CLS_W-1:0] CLS_FIRST_HIT  = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic is_cmp;
        logic is_merge;
        logic last;
    } cbcc_ctl_t;

    typedef struct packed {
        cbcc_ctl_t          ctl;
        logic [IDX_W-1:0]   entry_index;
        logic [VAL_W-1:0]   value;
    } cbcc_item_t;

    // Map a raw hit count onto its bucket
    function automatic logic [VAL_W-1:0] bucket_of(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] b;
        begin
            priority if (v[7])
                b = 8'd128;
            else if (v[6] || v[5])
                b = 8'd64;
            else if (v[4])
                b = 8'd32;
            else if (v[3])
                b = 8'd16;
            else if (v[2])
                b = 8'd8;
            else if (v == 8'd3)
                b = 8'd4;
            else
                b = v;
            return b;
        end
    endfunction

endpackage

// ----- rtl/cbcc_front.sv -----
// ============================================================================
// cbcc_front: input stage
// Accepts items, decodes the operation, buckets the hit count for the bucket
// modes and pushes the prepared item into the queue toward the back part.
// ============================================================================
module cbcc_front (
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // entry_index[15:0], hit_count[23:16]
    input  logic [cbcc_pkg::FUNC_W-1:0]      s_axis_tuser,  // func[1:0]
    input  logic                             s_axis_tlast,  // last_item
    input  logic                             init_done,
    input  logic                             q_full,
    output logic                             q_push,
    output cbcc_pkg::cbcc_item_t             q_item
);
    import cbcc_pkg::*;

    logic [VAL_W-1:0] raw;

    // Accept only once the map is cleared and the queue has room
    assign s_axis_tready = init_done && !q_full;
    assign q_push        = s_axis_tvalid && s_axis_tready;
    assign raw           = s_axis_tdata[IDX_W +: VAL_W];

    // Decode the operation and pick the value that travels on
    always_comb
    begin
        q_item.entry_index = s_axis_tdata[IDX_W-1:0];
        q_item.ctl.last    = s_axis_tlast;
        unique case (s_axis_tuser)
            FN_CMP_BKT:
            begin
                q_item.ctl.is_cmp   = 1'b1;
                q_item.ctl.is_merge = 1'b0;
                q_item.value        = bucket_of(raw);
            end
            FN_CMP_RAW:
            begin
                q_item.ctl.is_cmp   = 1'b1;
                q_item.ctl.is_merge = 1'b0;
                q_item.value        = raw;
            end
            FN_MERGE:
            begin
                q_item.ctl.is_cmp   = 1'b0;
                q_item.ctl.is_merge = 1'b1;
                q_item.value        = raw;
            end
            FN_BUCKET:
            begin
                q_item.ctl.is_cmp   = 1'b0;
                q_item.ctl.is_merge = 1'b0;
                q_item.value        = bucket_of(raw);
            end
            default:
            begin
                q_item.ctl.is_cmp   = 1'b0;
                q_item.ctl.is_merge = 1'b0;
                q_item.value        = raw;
            end
        endcase
    end

endmodule

// ----- rtl/cbcc_queue.sv -----
// ============================================================================
// cbcc_queue: short item queue
// Small register FIFO that decouples the front from the back part.
// ============================================================================
module cbcc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cbcc_pkg::cbcc_item_t  push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  valid,
    output cbcc_pkg::cbcc_item_t  head_item
);
    import cbcc_pkg::*;

    cbcc_item_t        slot_reg [QUEUE_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_CW-1:0]   cnt_reg;
    logic [Q_CW-1:0]   cnt_next;

    assign full      = (cnt_reg == Q_CW'(QUEUE_DEPTH));
    assign valid     = (cnt_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- rtl/cbcc_back.sv -----
// ============================================================================
// cbcc_back: map and counter stage
// Holds the seen map, reads it for each item, classifies compare items,
// merges into the map, keeps the pass totals and drives the output register.
// ============================================================================
module cbcc_back #(
    parameter int MAP_SIZE = cbcc_pkg::MAP_SIZE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  cbcc_pkg::cbcc_item_t             q_item,
    output logic                             q_pop,
    output logic                             init_done,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [47:0]                      m_axis_tdata,  // out_value[7:0],
                                                            // new_entry_count[24:8],
                                                            // new_bucket_count[41:25], zero
    output logic [cbcc_pkg::CLS_W-1:0]       m_axis_tuser,  // entry_class[1:0]
    output logic                             m_axis_tlast   // last_result
);
    import cbcc_pkg::*;

    localparam int AW = $clog2(MAP_SIZE);

    // Seen map
    logic [VAL_W-1:0]       map_mem [MAP_SIZE];
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [VAL_W-1:0]       mem_wd;
    logic [AW+IDX_W-1:0]    idx_ext;
    logic [AW-1:0]          q_addr;

    // Clearing sweep after reset
    logic                   clr_active_reg;
    logic [AW-1:0]          clr_addr_reg;

    // Map-read stage
    logic                   s2_valid_reg;
    cbcc_item_t             s2_item_reg;
    logic [AW-1:0]          s2_addr_reg;
    logic [VAL_W-1:0]       rd_data_reg;
    logic                   fwd_hit_reg;
    logic [VAL_W-1:0]       fwd_data_reg;
    logic                   s2_ready;

    // Classification
    logic [VAL_W-1:0]       old_val;
    logic                   is_new;
    logic                   fh_inc;
    logic                   nb_inc;
    logic                   pass_end;
    logic [CLS_W-1:0]       cls;
    logic [CNT_W-1:0]       fh_out;
    logic [CNT_W-1:0]       nb_out;

    // Pass totals
    logic [CNT_W-1:0]       fh_reg;
    logic [CNT_W-1:0]       fh_next;
    logic [CNT_W-1:0]       nb_reg;
    logic [CNT_W-1:0]       nb_next;

    // Output register
    logic                   out_valid_reg;
    logic                   out_load;
    logic [VAL_W-1:0]       out_value_reg;
    logic [CLS_W-1:0]       out_class_reg;
    logic [CNT_W-1:0]       out_fh_reg;
    logic [CNT_W-1:0]       out_nb_reg;
    logic                   out_last_reg;

    assign init_done = !clr_active_reg;

    // Wrap the entry index onto the map
    assign idx_ext = {{AW{1'b0}}, q_item.entry_index};
    assign q_addr  = idx_ext[AW-1:0];

    // Handshake between stages
    assign out_load = s2_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s2_ready = !s2_valid_reg || out_load;
    assign q_pop    = q_valid && s2_ready;

    // Pick the freshest map value and classify
    always_comb
    begin
        old_val  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        is_new   = ((s2_item_reg.value | old_val) != old_val);
        fh_inc   = s2_item_reg.ctl.is_cmp && is_new && (old_val == '0);
        nb_inc   = s2_item_reg.ctl.is_cmp && is_new && (old_val != '0);
        pass_end = s2_item_reg.ctl.is_cmp && s2_item_reg.ctl.last;
        if (fh_inc)
            cls = CLS_FIRST_HIT;
        else if (nb_inc)
            cls = CLS_NEW_BUCKET;
        else
            cls = CLS_NONE;
        fh_out = (fh_inc && fh_reg != CNT_MAX) ? fh_reg + 1'b1 : fh_reg;
        nb_out = (nb_inc && nb_reg != CNT_MAX) ? nb_reg + 1'b1 : nb_reg;
        fh_next = fh_reg;
        nb_next = nb_reg;
        if (out_load)
        begin
            fh_next = pass_end ? '0 : fh_out;
            nb_next = pass_end ? '0 : nb_out;
        end
    end

    // Map write port: clearing sweep or merge
    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_we = out_load && s2_item_reg.ctl.is_merge;
            mem_wa = s2_addr_reg;
            mem_wd = old_val | s2_item_reg.value;
        end
    end

    // Map storage and registered read, with bypass of a same-cycle write
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_wa] <= mem_wd;
        if (q_pop)
        begin
            rd_data_reg  <= map_mem[q_addr];
            fwd_hit_reg  <= mem_we && (mem_wa == q_addr);
            fwd_data_reg <= mem_wd;
            s2_item_reg  <= q_item;
            s2_addr_reg  <= q_addr;
        end
    end

    // Load output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= s2_item_reg.value;
            out_class_reg <= cls;
            out_fh_reg    <= fh_out;
            out_nb_reg    <= nb_out;
            out_last_reg  <= pass_end;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fh_reg         <= '0;
            nb_reg         <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == {AW{1'b1}})
                    clr_active_reg <= 1'b0;
            end
            if (s2_ready)
                s2_valid_reg <= q_valid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            fh_reg <= fh_next;
            nb_reg <= nb_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_nb_reg, out_fh_reg, out_value_reg};
    assign m_axis_tuser  = out_class_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- rtl/coverage_bitmap_classify_compare.sv -----
// ============================================================================
// coverage_bitmap_classify_compare: coverage map bucket classifier
// Buckets trace hit counts, compares them against a map of seen buckets,
// counts first hits and new buckets per pass, and merges into the map.
// ============================================================================
//  Channel   Dir  tdata (low bit up)                     tuser         tlast
//  s_axis    in   entry_index[15:0] hit_count[23:16]     func[1:0]     last_item
//  m_axis    out  out_value[7:0] new_entry_count[24:8]   entry_class   last_result
//                 new_bucket_count[41:25], zero above
//
//  Throughput is one item per cycle unless the output stalls; the accept
//  edge writes the queue, then the item passes the map read stage and the
//  output register. After reset the map is cleared one entry a cycle, with
//  s_axis_tready low until the sweep ends. A stalled output fills the output
//  register, read stage and four-entry queue before s_axis_tready drops.
// ============================================================================
module coverage_bitmap_classify_compare #(
    parameter int MAP_SIZE = cbcc_pkg::MAP_SIZE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // entry_index[15:0], hit_count[23:16]
    input  logic [cbcc_pkg::FUNC_W-1:0]      s_axis_tuser,  // func[1:0]
    input  logic                             s_axis_tlast,  // last_item
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [47:0]                      m_axis_tdata,  // out_value[7:0],
                                                            // new_entry_count[24:8],
                                                            // new_bucket_count[41:25], zero
    output logic [cbcc_pkg::CLS_W-1:0]       m_axis_tuser,  // entry_class[1:0]
    output logic                             m_axis_tlast   // last_result
);
    import cbcc_pkg::*;

    logic        init_done;
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    cbcc_item_t  push_item;
    cbcc_item_t  head_item;

    // Decode and bucket incoming items
    cbcc_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .init_done     (init_done),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    // Hold prepared items between the two parts
    cbcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_item (head_item)
    );

    // Map access, classification and totals
    cbcc_back #(
        .MAP_SIZE (MAP_SIZE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .init_done     (init_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- bench/cbcc_checker.sv -----
// ============================================================================
// cbcc_checker: result predictor and scoreboard for the bitmap classifier
// Watches both stream channels, keeps its own copy of the seen-bucket map and
// the per-pass totals, predicts one result for every accepted input item and
// compares each accepted output item field by field in arrival order.
// ============================================================================
module cbcc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [23:0]                   s_tdata,      // entry_index[15:0], hit_count[23:16]
    input  logic [cbcc_pkg::FUNC_W-1:0]   s_tuser,      // func[1:0]
    input  logic                          s_tlast,      // last_item
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [47:0]                   m_tdata,      // out_value[7:0], new_entry_count[24:8],
                                                        // new_bucket_count[41:25], zero above
    input  logic [cbcc_pkg::CLS_W-1:0]    m_tuser,      // entry_class[1:0]
    input  logic                          m_tlast,      // last_result
    output int                            fail_count,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import cbcc_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [CLS_W-1:0] cls;
        logic [CNT_W-1:0] first_hits;
        logic [CNT_W-1:0] new_buckets;
        logic             pass_end;
    } class_result_t;

    class_result_t    expected_q[$];
    logic [VAL_W-1:0] seen_map [0:65535];
    logic [CNT_W-1:0] first_hit_run;
    logic [CNT_W-1:0] new_bucket_run;
    int               mismatches;

    // Fold a raw hit count onto its bucket level
    function automatic logic [VAL_W-1:0] bucket_level(input logic [VAL_W-1:0] hits);
        if (hits >= 8'd128)
            return 8'd128;
        else if (hits >= 8'd32)
            return 8'd64;
        else if (hits >= 8'd16)
            return 8'd32;
        else if (hits >= 8'd8)
            return 8'd16;
        else if (hits >= 8'd4)
            return 8'd8;
        else if (hits == 8'd3)
            return 8'd4;
        else
            return hits;
    endfunction

    // Count up, holding at the top of the counter range
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    task automatic note_field(input string field, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0d ns: %s mismatch, expected %0d, got %0d",
                     $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [FUNC_W-1:0] op;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  hits;
        logic [VAL_W-1:0]  stored;
        class_result_t     res;
        class_result_t     want;
        if (!rst_n)
        begin
            for (int i = 0; i < 65536; i++)
                seen_map[i] = '0;
            first_hit_run  = '0;
            new_bucket_run = '0;
            mismatches     = 0;
            expected_q.delete();
            outstanding    <= 0;
            fail_count     <= 0;
        end
        else
        begin
            // Predict the result of an accepted input item
            if (s_tvalid && s_tready)
            begin
                op   = s_tuser;
                idx  = s_tdata[15:0];
                hits = s_tdata[23:16];
                res.value    = hits;
                res.cls      = CLS_NONE;
                res.pass_end = 1'b0;
                if (op == FN_CMP_BKT || op == FN_CMP_RAW)
                begin
                    stored = seen_map[idx];
                    if (op == FN_CMP_BKT)
                        res.value = bucket_level(hits);
                    if ((res.value | stored) != stored)
                    begin
                        if (stored == '0)
                        begin
                            res.cls       = CLS_FIRST_HIT;
                            first_hit_run = bump(first_hit_run);
                        end
                        else
                        begin
                            res.cls        = CLS_NEW_BUCKET;
                            new_bucket_run = bump(new_bucket_run);
                        end
                    end
                    res.pass_end = s_tlast;
                end
                else if (op == FN_MERGE)
                    seen_map[idx] = seen_map[idx] | hits;
                else
                    res.value = bucket_level(hits);
                res.first_hits  = first_hit_run;
                res.new_buckets = new_bucket_run;
                // Clear the totals once a pass has reported them
                if (res.pass_end)
                begin
                    first_hit_run  = '0;
                    new_bucket_run = '0;
                end
                expected_q.push_back(res);
            end

            // Compare an accepted output item with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0d ns: unexpected result, expected none, got %h/%0d/%0d",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    note_field("out_value", CNT_W'(want.value), CNT_W'(m_tdata[7:0]));
                    note_field("entry_class", CNT_W'(want.cls), CNT_W'(m_tuser));
                    note_field("new_entry_count", want.first_hits, m_tdata[24:8]);
                    note_field("new_bucket_count", want.new_buckets, m_tdata[41:25]);
                    note_field("last_result", CNT_W'(want.pass_end), CNT_W'(m_tlast));
                end
            end

            outstanding <= expected_q.size();
            fail_count  <= mismatches;
        end
    end

endmodule

// ----- bench/tb_coverage_bitmap_classify_compare.sv -----
// ============================================================================
// tb_coverage_bitmap_classify_compare: regression bench for the classifier
// Drives directed boundary items and random passes under several sender
// and receiver idling mixes; the checker beside the block predicts and
// compares every result.
// ============================================================================
module tb_coverage_bitmap_classify_compare;
    timeunit 1ns;
    timeprecision 1ps;

    import cbcc_pkg::*;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    wire                s_tready;
    logic [23:0]        s_tdata  = '0;
    logic [FUNC_W-1:0]  s_tuser  = FN_CMP_BKT;
    logic               s_tlast  = 1'b0;
    wire                m_tvalid;
    logic               m_tready = 1'b0;
    wire  [47:0]        m_tdata;
    wire  [CLS_W-1:0]   m_tuser;
    wire                m_tlast;

    int                 fail_count;
    int                 outstanding;
    int unsigned        send_idle_pct  = 0;
    int unsigned        recv_stall_pct = 0;

    always #5 clk = ~clk;

    coverage_bitmap_classify_compare DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    cbcc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Stall the result side at the current rate
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Offer one item, idling first at the current rate, and hold until taken
    task automatic push_item(input logic [FUNC_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] hits, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hits, idx};
        s_tuser  <= op;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending until every predicted result has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hit counts weighted toward bucket edges and single bits
    function automatic logic [VAL_W-1:0] pick_hits();
        int unsigned lvl;
        logic [VAL_W-1:0] pick;
        lvl = $urandom_range(8);
        case ($urandom_range(3))
            0:       pick = VAL_W'($urandom);
            1:       pick = VAL_W'($urandom_range(3));
            2:       pick = VAL_W'(1 << $urandom_range(7));
            default: pick = $urandom_range(1) ? VAL_W'((1 << lvl) - 1) : VAL_W'(1 << lvl);
        endcase
        return pick;
    endfunction

    // One pass of mixed operations, mostly on a hot window, closed by a last compare
    task automatic run_pass(input logic [IDX_W-1:0] base, input int unsigned len);
        logic [FUNC_W-1:0] op;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  hits;
        logic              last;
        int unsigned       roll;
        for (int unsigned n = 0; n < len; n++)
        begin
            roll = $urandom_range(99);
            idx  = ($urandom_range(99) < 85) ? base + IDX_W'($urandom_range(31))
                                              : IDX_W'($urandom);
            hits = pick_hits();
            last = 1'b0;
            if (n == len - 1)
            begin
                op   = $urandom_range(1) ? FN_CMP_RAW : FN_CMP_BKT;
                last = 1'b1;
            end
            else if (roll < 30)
            begin
                op   = FN_MERGE;
                last = 1'($urandom_range(1));
            end
            else if (roll < 85)
                op = roll[0] ? FN_CMP_RAW : FN_CMP_BKT;
            else if (roll < 95)
            begin
                op   = FN_BUCKET;
                last = 1'($urandom_range(1));
            end
            else
            begin
                // noise: any operation, any marker, possibly an early pass end
                op   = FUNC_W'($urandom);
                last = 1'($urandom_range(1));
            end
            push_item(op, idx, hits, last);
        end
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned items);
        int unsigned sent;
        int unsigned len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < items)
        begin
            len = $urandom_range(24, 4);
            run_pass(IDX_W'($urandom), len);
            sent += len;
        end
        hold_until_drained();
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: classes, pass end, ignored marker, index extremes
        push_item(FN_CMP_BKT, 16'd0,     8'd0,   1'b0);
        push_item(FN_CMP_BKT, 16'hFFFF,  8'd255, 1'b0);
        push_item(FN_MERGE,   16'hFFFF,  8'd1,   1'b0);
        push_item(FN_CMP_RAW, 16'hFFFF,  8'd2,   1'b0);
        push_item(FN_CMP_RAW, 16'hFFFF,  8'd1,   1'b0);
        push_item(FN_MERGE,   16'd0,     8'd255, 1'b1);
        push_item(FN_CMP_BKT, 16'd0,     8'd3,   1'b1);
        push_item(FN_CMP_RAW, 16'd300,   8'd128, 1'b0);
        // Bucket edges through bucket-only mode
        for (int k = 0; k <= 8; k++)
            push_item(FN_BUCKET, IDX_W'(k), VAL_W'((1 << k) - 1), 1'b0);
        for (int k = 0; k <= 7; k++)
            push_item(FN_BUCKET, IDX_W'(k), VAL_W'(1 << k), k == 7);
        hold_until_drained();

        // Random passes under each idling mix
        run_phase(0,  0,  300);
        run_phase(53, 0,  300);
        run_phase(0,  53, 300);
        run_phase(36, 36, 300);

        recv_stall_pct = 0;
        repeat (16) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("coverage_bitmap_classify_compare regression: pass");
        else
            $display("coverage_bitmap_classify_compare regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(20_000_000);
        $display("coverage_bitmap_classify_compare regression: fail");
        $finish;
    end

endmodule
